// File: hw/rtl/assert_macros.svh
// Assertion macros of the box blur RTL, used by bb_window
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BB_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");
`define BB_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("%m: assertion failed");
`else
`define BB_ASSERT(name, clk, rstn, prop)
`define BB_ASSERT_NEXT(name, clk, rstn, pre, post)
`endif
`endif

// File: hw/rtl/bb_pkg.sv
// Types, constants and the reciprocal table of the 3x3 box blur
package bb_pkg;

  localparam int unsigned CfgW       = 13;
  localparam int unsigned RowW       = 13;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned PixW       = 24;
  localparam int unsigned SumW       = 12;
  localparam int unsigned RecipW     = 17;
  localparam int unsigned RecipShift = 16;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_WIDTH  = 1'b0;
  localparam cfg_idx_t REG_HEIGHT = 1'b1;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } pix_out_t;

  // result of one window step, handed to the output stage
  typedef struct packed {
    logic            emit;
    logic            last;
    logic [1:0]      hcnt;
    logic [1:0]      vcnt;
    logic [SumW-1:0] sum_r;
    logic [SumW-1:0] sum_g;
    logic [SumW-1:0] sum_b;
  } win_res_t;

  // ceil(2^16 / d); exact floor for sums up to 9*255
  function automatic logic [RecipW-1:0] recip(input logic [1:0] hcnt, input logic [1:0] vcnt);
    logic [3:0]        d;
    logic [RecipW-1:0] m;
    d = {2'b00, hcnt} * {2'b00, vcnt};
    case (d)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10923;
      4'd9:    m = 17'd7282;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/bb_stream_if.sv
// Valid/ready stream channel carrying one payload struct
interface bb_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/bb_line_mem.sv
// Column store: upper and middle line pixels per column, registered read
module bb_line_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [AddrW-1:0]             rd_addr_i,
  output logic [2*bb_pkg::PixW-1:0]    rd_data_o,
  input  logic                         wr_en_i,
  input  logic [AddrW-1:0]             wr_addr_i,
  input  logic [2*bb_pkg::PixW-1:0]    wr_data_i
);
  import bb_pkg::*;

  localparam int unsigned DataW = 2 * PixW;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/bb_window.sv
// 3x3 window, raster counters and neighborhood sums
`include "assert_macros.svh"

module bb_window #(
  parameter int unsigned ColW = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       restart_i,
  input  logic                       step_i,
  input  bb_pkg::pix_in_t            item_i,
  input  logic [ColW:0]              eff_w_i,
  input  logic [bb_pkg::RowW-1:0]    eff_h_i,
  output logic [ColW-1:0]            col_o,
  input  logic [2*bb_pkg::PixW-1:0]  rd_data_i,
  output logic                       wr_en_o,
  output logic [2*bb_pkg::PixW-1:0]  wr_data_o,
  output bb_pkg::win_res_t           res_o
);
  import bb_pkg::*;

  logic [PixW-1:0] win_q [9];
  logic [PixW-1:0] win_d [9];
  logic [ColW-1:0] in_col_q, out_col_q;
  logic [RowW-1:0] in_row_q, out_row_q;
  logic            done_q;

  logic            adv, emit, last;
  logic            left, right, top, bottom;
  logic [PixW-1:0] pix, up, mid;
  logic [ColW:0]   in_col_inc, out_col_inc;
  logic            in_wrap, out_wrap;
  logic [2:0]      col_ok, row_ok;
  logic [9:0]      row_r [3];
  logic [9:0]      row_g [3];
  logic [9:0]      row_b [3];
  logic            last_step, cnt_clear;

  assign adv = !(item_i.operation == OP_DRAIN && !done_q);
  assign pix = done_q ? '0 : {item_i.in_red, item_i.in_green, item_i.in_blue};
  assign up  = rd_data_i[2*PixW-1:PixW];
  assign mid = rd_data_i[PixW-1:0];

  assign col_o     = in_col_q;
  assign wr_en_o   = step_i && adv && !done_q;
  assign wr_data_o = {mid, pix};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = up;
    win_d[5] = mid;
    win_d[8] = pix;
  end

  assign emit = (in_row_q >= RowW'(2)) || (in_row_q == RowW'(1) && in_col_q != '0);

  assign out_col_inc = (ColW+1)'(out_col_q) + (ColW+1)'(1);
  assign in_col_inc  = (ColW+1)'(in_col_q) + (ColW+1)'(1);
  assign in_wrap     = in_col_inc >= eff_w_i;
  assign out_wrap    = out_col_inc >= eff_w_i;

  assign left   = out_col_q != '0;
  assign right  = !out_wrap;
  assign top    = out_row_q != '0;
  assign bottom = (out_row_q + RowW'(1)) < eff_h_i;
  assign last   = !right && !bottom;

  assign col_ok = {right, 1'b1, left};
  assign row_ok = {bottom, 1'b1, top};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_r[r] = '0;
      row_g[r] = '0;
      row_b[r] = '0;
      for (int k = 0; k < 3; k++) begin
        if (col_ok[k]) begin
          row_r[r] = row_r[r] + 10'(win_d[r*3+k][23:16]);
          row_g[r] = row_g[r] + 10'(win_d[r*3+k][15:8]);
          row_b[r] = row_b[r] + 10'(win_d[r*3+k][7:0]);
        end
      end
      if (!row_ok[r]) begin
        row_r[r] = '0;
        row_g[r] = '0;
        row_b[r] = '0;
      end
    end
  end

  always_comb begin
    res_o.emit  = adv && emit;
    res_o.last  = last;
    res_o.hcnt  = 2'd1 + {1'b0, left} + {1'b0, right};
    res_o.vcnt  = 2'd1 + {1'b0, top} + {1'b0, bottom};
    res_o.sum_r = SumW'(row_r[0]) + SumW'(row_r[1]) + SumW'(row_r[2]);
    res_o.sum_g = SumW'(row_g[0]) + SumW'(row_g[1]) + SumW'(row_g[2]);
    res_o.sum_b = SumW'(row_b[0]) + SumW'(row_b[1]) + SumW'(row_b[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      done_q    <= 1'b0;
    end else if (restart_i || (step_i && adv && emit && last)) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      done_q    <= 1'b0;
    end else if (step_i && adv) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
      if (!done_q && in_row_q == eff_h_i - RowW'(1) && in_wrap) begin
        done_q <= 1'b1;
      end
      if (in_wrap) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + RowW'(1);
      end else begin
        in_col_q <= in_col_inc[ColW-1:0];
      end
      if (emit) begin
        if (out_wrap) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + RowW'(1);
        end else begin
          out_col_q <= out_col_inc[ColW-1:0];
        end
      end
    end
  end

  assign last_step = step_i && res_o.emit && res_o.last;
  assign cnt_clear = in_row_q == '0 && in_col_q == '0 && !done_q;

  `BB_ASSERT_NEXT(a_last_restarts, clk_i, rst_ni, last_step, cnt_clear)
  `BB_ASSERT(a_done_past_rows, clk_i, rst_ni, !done_q || in_row_q >= eff_h_i)
  `BB_ASSERT(a_out_in_image, clk_i, rst_ni, out_row_q < eff_h_i && (ColW+1)'(out_col_q) < eff_w_i)

endmodule

// File: hw/rtl/bb_out_stage.sv
// Pending sums, reciprocal multiply and output register
module bb_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bb_pkg::win_res_t  res_i,
  output logic              can_load_o,
  bb_stream_if.source       out_o
);
  import bb_pkg::*;

  localparam int unsigned ProdW = SumW + RecipW;

  logic              pend_valid_q, out_valid_q;
  logic [SumW-1:0]   sum_r_q, sum_g_q, sum_b_q;
  logic [RecipW-1:0] recip_q;
  logic              last_q;
  pix_out_t          out_q;
  logic              drain;
  logic [ProdW-1:0]  prod_r, prod_g, prod_b;

  assign drain      = pend_valid_q && (!out_valid_q || out_o.ready);
  assign can_load_o = !pend_valid_q || drain;

  assign prod_r = ProdW'(sum_r_q) * ProdW'(recip_q);
  assign prod_g = ProdW'(sum_g_q) * ProdW'(recip_q);
  assign prod_b = ProdW'(sum_b_q) * ProdW'(recip_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (load_i) begin
        pend_valid_q <= 1'b1;
      end else if (drain) begin
        pend_valid_q <= 1'b0;
      end
      if (drain) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_r_q <= res_i.sum_r;
      sum_g_q <= res_i.sum_g;
      sum_b_q <= res_i.sum_b;
      recip_q <= recip(res_i.hcnt, res_i.vcnt);
      last_q  <= res_i.last;
    end
    if (drain) begin
      out_q.out_red    <= prod_r[RecipShift+7:RecipShift];
      out_q.out_green  <= prod_g[RecipShift+7:RecipShift];
      out_q.out_blue   <= prod_b[RecipShift+7:RecipShift];
      out_q.frame_last <= last_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// File: hw/rtl/box_blur_3x3.sv
// Top level of the 3x3 box blur over RGB888 raster pixels
//
//   channel   dir  payload                                   transaction
//   in_i      in   operation, in_red, in_green, in_blue      valid & ready
//   out_o     out  out_red, out_green, out_blue, frame_last  valid & ready
//   cfg       in   cfg_idx_i, cfg_data_i (13 bits)           cfg_we_i
//
// Each input transaction is accepted with the column-store read; the window
// step on the read data follows, and input stays held off until it is done.
// Results pass a pending register and a reciprocal multiply into the output
// register; a stalled output holds off input only once the pending register
// is also full. No clearing pass after reset; config writes restart the image.
module box_blur_3x3 #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  bb_stream_if.sink               in_i,
  bb_stream_if.source             out_o,
  input  logic                    cfg_we_i,
  input  bb_pkg::cfg_idx_t        cfg_idx_i,
  input  logic [bb_pkg::CfgW-1:0] cfg_data_i
);
  import bb_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [CfgW-1:0]     width_q, height_q;
  logic [ColW:0]       eff_w;
  logic [RowW-1:0]     eff_h;
  pix_in_t             item_q;
  logic                accept, step, can_load;
  logic [ColW-1:0]     col;
  logic [2*PixW-1:0]   rd_data, wr_data;
  logic                wr_en;
  win_res_t            res;

  always_comb begin
    if (width_q == '0) begin
      eff_w = (ColW+1)'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = (ColW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (ColW+1)'(width_q);
    end
    if (height_q == '0) begin
      eff_h = RowW'(1);
    end else if (32'(height_q) > MaxHeight) begin
      eff_h = RowW'(MaxHeight);
    end else begin
      eff_h = RowW'(height_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(640);
      height_q <= CfgW'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE) && can_load;
  assign accept     = in_i.valid && in_i.ready;
  assign step       = state_q == ST_EXEC;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i.data;
    end
  end

  bb_line_mem #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (col),
    .wr_data_i (wr_data)
  );

  bb_window #(
    .ColW (ColW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .step_i    (step),
    .item_i    (item_q),
    .eff_w_i   (eff_w),
    .eff_h_i   (eff_h),
    .col_o     (col),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_data_o (wr_data),
    .res_o     (res)
  );

  bb_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && res.emit),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

// File: dv/box_blur_3x3_tb.sv
// Self-checking testbench of the 3x3 box blur: directed table, random images, stall phases
`timescale 1ns / 100ps

module box_blur_3x3_tb;
  import bb_pkg::*;

  localparam int unsigned MAX_W    = 4096;
  localparam int unsigned IDLE_GAP = 16;
  localparam int unsigned DIR_ROWS = 31;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_TYPED,
    ROW_PRED
  } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    cfg_idx_t        idx;
    logic [CfgW-1:0] val;
    pix_in_t         item;
    logic            has_res;
    pix_out_t        res;
  } dir_row_t;

  localparam pix_in_t  NO_PIX = '{OP_DRAIN, 8'd0, 8'd0, 8'd0};
  localparam pix_out_t NO_RES = '0;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  cfg_idx_t        cfg_idx;
  logic [CfgW-1:0] cfg_data;

  bb_stream_if #(.T(pix_in_t))  in_if ();
  bb_stream_if #(.T(pix_out_t)) out_if ();

  box_blur_3x3 #(
    .MAX_WIDTH(MAX_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // blur predictor state
  logic [CfgW-1:0] blur_w_reg;
  logic [CfgW-1:0] blur_h_reg;
  logic [PixW-1:0] blur_upper [MAX_W];
  logic [PixW-1:0] blur_middle [MAX_W];
  logic [PixW-1:0] blur_win [9];
  int unsigned     in_col, in_row, out_col, out_row;
  bit              frame_in_done;

  pix_out_t    blurred_q [$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned stim_count;
  int unsigned image_count;
  int unsigned cut_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  dir_row_t dir_table [DIR_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [CfgW-1:0] v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic void restart_blur();
    for (int i = 0; i < 9; i++) blur_win[i] = '0;
    in_col        = 0;
    in_row        = 0;
    out_col       = 0;
    out_row       = 0;
    frame_in_done = 1'b0;
  endfunction

  function automatic bit blur_step(input pix_in_t item, output pix_out_t res);
    int unsigned     w, h, c, cnt, sum_r, sum_g, sum_b;
    logic [PixW-1:0] pix, up, mid, p;
    bit              emit, left, right, top, bottom, last;
    w   = clamp_dim(blur_w_reg, MAX_W);
    h   = clamp_dim(blur_h_reg, MaxHeight);
    res = NO_RES;
    if (!frame_in_done && item.operation == OP_DRAIN) return 1'b0;
    pix = frame_in_done ? '0 : {item.in_red, item.in_green, item.in_blue};
    c   = (in_col >= MAX_W) ? 0 : in_col;
    up  = blur_upper[c];
    mid = blur_middle[c];
    if (!frame_in_done) begin
      blur_upper[c]  = mid;
      blur_middle[c] = pix;
    end
    for (int r = 0; r < 3; r++) begin
      blur_win[r * 3]     = blur_win[r * 3 + 1];
      blur_win[r * 3 + 1] = blur_win[r * 3 + 2];
    end
    blur_win[2] = up;
    blur_win[5] = mid;
    blur_win[8] = pix;
    emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
    if (!frame_in_done && in_row == h - 1 && in_col == w - 1) frame_in_done = 1'b1;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return 1'b0;
    left   = out_col > 0;
    right  = out_col + 1 < w;
    top    = out_row > 0;
    bottom = out_row + 1 < h;
    cnt    = (1 + left + right) * (1 + top + bottom);
    sum_r  = 0;
    sum_g  = 0;
    sum_b  = 0;
    for (int r = 0; r < 3; r++) begin
      if ((r == 0 && !top) || (r == 2 && !bottom)) continue;
      for (int k = 0; k < 3; k++) begin
        if ((k == 0 && !left) || (k == 2 && !right)) continue;
        p = blur_win[r * 3 + k];
        sum_r += p[23:16];
        sum_g += p[15:8];
        sum_b += p[7:0];
      end
    end
    last           = (out_row + 1 >= h) && (out_col + 1 >= w);
    res.out_red    = 8'(sum_r / cnt);
    res.out_green  = 8'(sum_g / cnt);
    res.out_blue   = 8'(sum_b / cnt);
    res.frame_last = last;
    if (last) begin
      restart_blur();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  function automatic pix_in_t rand_item(input op_e op);
    pix_in_t item;
    item.operation = op;
    {item.in_red, item.in_green, item.in_blue} = 24'($urandom);
    return item;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned got, input int unsigned want);
    mismatch_count++;
    $display("%0t ns: %s mismatch on result %0d: got %0d, expected %0d",
             $time, what, result_count, got, want);
  endtask

  // all stimulus tasks start and end at a falling edge
  task automatic drive_item(input pix_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_item(input pix_in_t item, output bit got_last);
    pix_out_t res;
    got_last = 1'b0;
    if (blur_step(item, res)) begin
      blurred_q.push_back(res);
      got_last = res.frame_last;
    end
    drive_item(item);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (blurred_q.size() != 0) @(negedge clk_i);
    repeat (IDLE_GAP) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == REG_WIDTH) blur_w_reg = val;
    else blur_h_reg = val;
    restart_blur();
    @(negedge clk_i);
  endtask

  task automatic run_image(input int unsigned w_val, input int unsigned h_val,
                           input bit counted, input bit cut_short);
    int unsigned npix, nsend;
    bit          done;
    wait_idle();
    write_reg(REG_WIDTH, 13'(w_val));
    write_reg(REG_HEIGHT, 13'(h_val));
    npix  = clamp_dim(13'(w_val), MAX_W) * clamp_dim(13'(h_val), MaxHeight);
    nsend = (cut_short && npix > 1) ? $urandom_range(npix - 1, 1) : npix;
    done  = 1'b0;
    for (int unsigned i = 0; i < nsend; i++) begin
      // drain mid-image is dropped by the block
      if ($urandom_range(15) == 0) send_item(rand_item(OP_DRAIN), done);
      send_item(rand_item(OP_PIXEL), done);
      if (counted) stim_count++;
    end
    if (nsend < npix) begin
      cut_count++;
      return;
    end
    while (!done) begin
      // a pixel after the frame is complete acts as a drain
      send_item(rand_item($urandom_range(7) == 0 ? OP_PIXEL : OP_DRAIN), done);
      if (counted) stim_count++;
    end
    if ($urandom_range(3) == 0) send_item(rand_item(OP_DRAIN), done);
    image_count++;
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : out_check
    pix_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (blurred_q.size() == 0) begin
        note_mismatch("unexpected output", 32'(out_if.data), 0);
      end else begin
        want = blurred_q.pop_front();
        if (out_if.data.out_red !== want.out_red)
          note_mismatch("out_red", 32'(out_if.data.out_red), 32'(want.out_red));
        if (out_if.data.out_green !== want.out_green)
          note_mismatch("out_green", 32'(out_if.data.out_green), 32'(want.out_green));
        if (out_if.data.out_blue !== want.out_blue)
          note_mismatch("out_blue", 32'(out_if.data.out_blue), 32'(want.out_blue));
        if (out_if.data.frame_last !== want.frame_last)
          note_mismatch("frame_last", 32'(out_if.data.frame_last), 32'(want.frame_last));
      end
      result_count++;
    end
  end

  initial begin
    dir_row_t    row;
    pix_out_t    scratch;
    bit          done;
    int unsigned wv, hv, sel, target;
    int unsigned phase_idle [4];
    int unsigned phase_stall [4];

    phase_idle     = '{0, 50, 0, 32};
    phase_stall    = '{0, 0, 50, 32};
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_WIDTH;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    result_count   = 0;
    stim_count     = 0;
    image_count    = 0;
    cut_count      = 0;
    blur_w_reg     = 13'd640;
    blur_h_reg     = 13'd480;
    for (int i = 0; i < MAX_W; i++) begin
      blur_upper[i]  = '0;
      blur_middle[i] = '0;
    end
    restart_blur();

    dir_table = '{
      // drain before any frame: nothing happens
      '{ROW_TYPED, REG_WIDTH,  13'd0, NO_PIX, 1'b0, NO_RES},
      // zero sizes clamp to a 1x1 frame
      '{ROW_REG,   REG_WIDTH,  13'd0, NO_PIX, 1'b0, NO_RES},
      '{ROW_REG,   REG_HEIGHT, 13'd0, NO_PIX, 1'b0, NO_RES},
      '{ROW_TYPED, REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd255, 8'd0, 8'd128}, 1'b0, NO_RES},
      '{ROW_TYPED, REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd1, 8'd2, 8'd3}, 1'b0, NO_RES},
      '{ROW_TYPED, REG_WIDTH,  13'd0, NO_PIX, 1'b1, '{8'd255, 8'd0, 8'd128, 1'b1}},
      // 2x2: every output is a corner averaging all four pixels
      '{ROW_REG,   REG_WIDTH,  13'd2, NO_PIX, 1'b0, NO_RES},
      '{ROW_REG,   REG_HEIGHT, 13'd2, NO_PIX, 1'b0, NO_RES},
      '{ROW_TYPED, REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd255, 8'd0, 8'd0}, 1'b0, NO_RES},
      '{ROW_TYPED, REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd0, 8'd255, 8'd0}, 1'b0, NO_RES},
      '{ROW_TYPED, REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd0, 8'd0, 8'd255}, 1'b0, NO_RES},
      '{ROW_TYPED, REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd255, 8'd255, 8'd255}, 1'b1,
        '{8'd127, 8'd127, 8'd127, 1'b0}},
      '{ROW_TYPED, REG_WIDTH,  13'd0, NO_PIX, 1'b1, '{8'd127, 8'd127, 8'd127, 1'b0}},
      '{ROW_TYPED, REG_WIDTH,  13'd0, NO_PIX, 1'b1, '{8'd127, 8'd127, 8'd127, 1'b0}},
      '{ROW_TYPED, REG_WIDTH,  13'd0, NO_PIX, 1'b1, '{8'd127, 8'd127, 8'd127, 1'b1}},
      '{ROW_TYPED, REG_WIDTH,  13'd0, NO_PIX, 1'b0, NO_RES},
      // 3x3: corners, edges and a full center window
      '{ROW_REG,   REG_WIDTH,  13'd3, NO_PIX, 1'b0, NO_RES},
      '{ROW_REG,   REG_HEIGHT, 13'd3, NO_PIX, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd0, 8'd0, 8'd0}, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd255, 8'd255, 8'd255}, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd17, 8'd34, 8'd51}, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd200, 8'd100, 8'd50}, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd255, 8'd0, 8'd255}, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd1, 8'd254, 8'd128}, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd99, 8'd99, 8'd99}, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd0, 8'd255, 8'd0}, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd128, 8'd128, 8'd128}, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, NO_PIX, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, '{OP_PIXEL, 8'd7, 8'd7, 8'd7}, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, NO_PIX, 1'b0, NO_RES},
      '{ROW_PRED,  REG_WIDTH,  13'd0, NO_PIX, 1'b0, NO_RES}
    };

    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_table[i];
      case (row.kind)
        ROW_REG: begin
          wait_idle();
          write_reg(row.idx, row.val);
        end
        ROW_TYPED: begin
          void'(blur_step(row.item, scratch));
          if (row.has_res) blurred_q.push_back(row.res);
          drive_item(row.item);
        end
        default: send_item(row.item, done);
      endcase
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      target         = stim_count + 175;
      while (stim_count < target) begin
        sel = $urandom_range(9);
        if (sel < 6) begin
          wv = $urandom_range(12, 1);
          hv = $urandom_range(9, 1);
        end else if (sel < 8) begin
          wv = $urandom_range(64, 13);
          hv = $urandom_range(4, 1);
        end else begin
          wv = $urandom_range(3, 0);
          hv = $urandom_range(40, 0);
        end
        run_image(wv, hv, 1'b1, $urandom_range(9) == 0);
      end
    end

    wait_idle();
    $display("Covered: %0d complete frames, %0d cut short, %0d random transactions",
             image_count, cut_count, stim_count);
    $display("Checked %0d blurred pixels, %0d mismatches", result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/bb_pkg.sv
hw/rtl/bb_stream_if.sv
hw/rtl/bb_line_mem.sv
hw/rtl/bb_window.sv
hw/rtl/bb_out_stage.sv
hw/rtl/box_blur_3x3.sv
dv/box_blur_3x3_tb.sv
